### hdl/asl_pkg.sv
// shared types and constants for the analog scale / low-pass block
// used by asl_mul, asl_div and analog_scale_lowpass_core; no dependencies
package asl_pkg;

  // field and register widths
  localparam int ELAPSED_W    = 16;
  localparam int RAW_SAMPLE_W = 12;
  localparam int VALUE_W      = 32;
  localparam int ACC_W        = 32;
  localparam int FS_W         = 12;
  localparam int TAU_W        = 20;
  localparam int DT_W         = 31;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  // block constants
  localparam int unsigned SAMPLE_INTERVAL_MS = 10;
  localparam int unsigned RAW_BITS_DEF       = 12;
  localparam logic signed [VALUE_W-1:0] SCALED_MAX_RST = 32'sd6553600;
  localparam logic [FS_W-1:0]           FULL_SCALE_RST = 12'd4095;

  // serial multiplier: signed multiplicand times unsigned multiplier
  localparam int MCAND_W   = 33;
  localparam int MPLIER_W  = 32;
  localparam int PROD_W    = MCAND_W + 1 + MPLIER_W;
  localparam int MUL_CNT_W = 6;

  // serial divider: unsigned numerator over unsigned denominator
  localparam int NUM_W     = 64;
  localparam int DEN_W     = 32;
  localparam int DIV_CNT_W = 7;

  typedef struct packed {
    logic                 start;
    logic [MUL_CNT_W-1:0] count;
  } mul_cmd_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] count;
  } div_cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE     = 3'd0,
    REG_SCALED_MIN = 3'd1,
    REG_SCALED_MAX = 3'd2,
    REG_FULL_SCALE = 3'd3,
    REG_FILTER_MS  = 3'd4
  } asl_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL_SCALE,
    ST_ABS,
    ST_LOAD,
    ST_DIV,
    ST_POST,
    ST_MUL_PREV,
    ST_MUL_NEW,
    ST_OUT
  } asl_state_e;

endpackage

### hdl/analog_scale_lowpass_core.sv
// linear scaling of a raw converter sample followed by a first-order low-pass
// top level; depends on asl_pkg, asl_mul and asl_div
//
// input channel (in_valid_i / in_stall_o) carries elapsed_ms_i and raw_sample_i;
// output channel (out_valid_o / out_stall_i) returns one item per input item:
// filtered_value_o (signed q16.16) and updated_o.
// elapsed time adds into a saturating accumulator; once enabled, with min and
// max apart and the interval reached, the sample is scaled and filtered and
// the accumulator clears.
// one item is worked at a time. an item that takes no sample skips both units;
// an item that updates runs through one shared bit-serial multiplier (three
// products of RAW_BITS, 20 and 31 bits) and one restoring divider (RAW_BITS+33
// and 64 quotient bits).
// results sit in an output register; the next item is taken while it waits,
// and a stalled receiver only holds the block once the next result is ready.
// reset clears the state, the accumulator and the filter to zero and loads
// register defaults. config writes on cfg_we_i take effect at once and belong
// to idle periods only.
module analog_scale_lowpass_core #(
  parameter int unsigned RAW_BITS = asl_pkg::RAW_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic        [asl_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic        [asl_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic        [asl_pkg::ELAPSED_W-1:0]   elapsed_ms_i,
  input  logic        [asl_pkg::RAW_SAMPLE_W-1:0] raw_sample_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [asl_pkg::VALUE_W-1:0]     filtered_value_o,
  output logic                                   updated_o
);
  import asl_pkg::*;

  localparam int RAW_EXT_W  = (RAW_BITS > RAW_SAMPLE_W) ? RAW_BITS : RAW_SAMPLE_W;
  localparam int SCALE_BITS = RAW_BITS + MCAND_W;
  localparam int SCALE_ALIGN = NUM_W - SCALE_BITS;
  localparam int SCALE_SHIFT = MPLIER_W - RAW_BITS;
  localparam int TAU_SHIFT  = MPLIER_W - TAU_W;
  localparam int DT_SHIFT   = MPLIER_W - DT_W;

  function automatic logic signed [VALUE_W-1:0] sat_value(
    input logic signed [PROD_W-1:0] v
  );
    logic [PROD_W-VALUE_W:0] top;
    top = v[PROD_W-1:VALUE_W-1];
    if (&top || ~|top) begin
      return v[VALUE_W-1:0];
    end
    return v[PROD_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
  endfunction

  // configuration
  logic                        enable_q;
  logic signed [VALUE_W-1:0]   scaled_min_q;
  logic signed [VALUE_W-1:0]   scaled_max_q;
  logic [FS_W-1:0]             full_scale_q;
  logic [TAU_W-1:0]            tau_q;

  // control and state
  asl_state_e                  state_q, state_d;
  logic [ACC_W-1:0]            acc_q;
  logic signed [VALUE_W-1:0]   smoothed_q;
  logic                        filt_q;
  logic                        upd_q;
  logic                        out_valid_q;

  // datapath
  logic [RAW_BITS-1:0]         raw_q;
  logic [DT_W-1:0]             dt_q;
  logic signed [VALUE_W-1:0]   scaled_q;
  logic signed [NUM_W-1:0]     p2_q;
  logic signed [NUM_W-1:0]     num_q;
  logic [NUM_W-1:0]            mag_q;
  logic                        neg_q;
  logic [DEN_W-1:0]            den_q;
  logic signed [VALUE_W-1:0]   out_value_q;
  logic                        out_upd_q;

  logic                        in_accept;
  logic                        out_free;
  logic                        ready;
  logic [ACC_W:0]              acc_sum;
  logic [ACC_W-1:0]            acc_sat;
  logic [RAW_EXT_W-1:0]        raw_ext;
  logic [FS_W-1:0]             fs_eff;
  logic signed [MCAND_W-1:0]   span;
  logic [DT_W-1:0]             dt_cap;
  logic signed [PROD_W-1:0]    abs_src;
  logic signed [PROD_W-1:0]    abs_mag;
  logic [NUM_W-1:0]            div_val;
  logic signed [PROD_W-1:0]    quo_s;
  logic signed [PROD_W-1:0]    post_sum;
  logic signed [VALUE_W-1:0]   post_sat;

  mul_cmd_t                    mul_cmd;
  logic signed [MCAND_W-1:0]   mul_mcand;
  logic [MPLIER_W-1:0]         mul_mplier;
  logic                        mul_done;
  logic signed [PROD_W-1:0]    mul_prod;
  div_cmd_t                    div_cmd;
  logic [NUM_W-1:0]            div_num;
  logic                        div_done;
  logic [NUM_W-1:0]            div_quo;

  asl_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (mul_cmd),
    .mcand_i  (mul_mcand),
    .mplier_i (mul_mplier),
    .done_o   (mul_done),
    .prod_o   (mul_prod)
  );

  asl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .num_i  (div_num),
    .den_i  (den_q),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;

  assign acc_sum = {1'b0, acc_q} + (ACC_W + 1)'(elapsed_ms_i);
  assign acc_sat = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
  assign raw_ext = RAW_EXT_W'(raw_sample_i);

  assign ready  = enable_q && (scaled_max_q != scaled_min_q) &&
                  (acc_q >= ACC_W'(SAMPLE_INTERVAL_MS));
  assign fs_eff = (full_scale_q == '0) ? FS_W'(1) : full_scale_q;
  assign span   = $signed({scaled_max_q[VALUE_W-1], scaled_max_q}) -
                  $signed({scaled_min_q[VALUE_W-1], scaled_min_q});
  assign dt_cap = acc_q[ACC_W-1] ? '1 : acc_q[DT_W-1:0];

  // magnitude and sign of the dividend: scaled product or filter numerator
  assign abs_src = filt_q ? $signed({{(PROD_W-NUM_W){num_q[NUM_W-1]}}, num_q})
                          : (mul_prod >>> SCALE_SHIFT);
  assign abs_mag = abs_src[PROD_W-1] ? -abs_src : abs_src;

  // round half away from zero by adding half the divisor to the magnitude
  assign div_val = mag_q + NUM_W'(den_q >> 1);
  assign div_num = filt_q ? div_val : (div_val << SCALE_ALIGN);

  assign quo_s    = $signed({{(PROD_W-NUM_W){1'b0}}, div_quo});
  assign post_sum = (neg_q ? -quo_s : quo_s) +
                    (filt_q ? '0 : $signed({{(PROD_W-VALUE_W){scaled_min_q[VALUE_W-1]}},
                                            scaled_min_q}));
  assign post_sat = sat_value(post_sum);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_CHECK;
      ST_CHECK:     state_d = ready ? ST_MUL_SCALE : ST_OUT;
      ST_MUL_SCALE: if (mul_done) state_d = ST_ABS;
      ST_ABS:       state_d = ST_LOAD;
      ST_LOAD:      state_d = ST_DIV;
      ST_DIV:       if (div_done) state_d = ST_POST;
      ST_POST:      state_d = filt_q ? ST_OUT : ST_MUL_PREV;
      ST_MUL_PREV:  if (mul_done) state_d = ST_MUL_NEW;
      ST_MUL_NEW:   if (mul_done) state_d = ST_ABS;
      ST_OUT:       if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // unit commands and operand selection
  always_comb begin
    in_stall_o    = 1'b1;
    mul_cmd       = '0;
    mul_mcand     = '0;
    mul_mplier    = '0;
    div_cmd       = '0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      ST_CHECK: begin
        mul_cmd.start = ready;
        mul_cmd.count = MUL_CNT_W'(RAW_BITS);
        mul_mcand     = span;
        mul_mplier    = MPLIER_W'(raw_q);
      end
      ST_LOAD: begin
        div_cmd.start = 1'b1;
        div_cmd.count = filt_q ? DIV_CNT_W'(NUM_W) : DIV_CNT_W'(SCALE_BITS);
      end
      ST_POST: begin
        // previous value times the time constant
        mul_cmd.start = !filt_q;
        mul_cmd.count = MUL_CNT_W'(TAU_W);
        mul_mcand     = $signed({smoothed_q[VALUE_W-1], smoothed_q});
        mul_mplier    = MPLIER_W'(tau_q);
      end
      ST_MUL_PREV: begin
        // new scaled value times the elapsed weight
        mul_cmd.start = mul_done;
        mul_cmd.count = MUL_CNT_W'(DT_W);
        mul_mcand     = $signed({scaled_q[VALUE_W-1], scaled_q});
        mul_mplier    = MPLIER_W'(dt_q);
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      scaled_min_q <= '0;
      scaled_max_q <= SCALED_MAX_RST;
      full_scale_q <= FULL_SCALE_RST;
      tau_q        <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ENABLE:     enable_q     <= cfg_data_i[0];
        REG_SCALED_MIN: scaled_min_q <= $signed(cfg_data_i[VALUE_W-1:0]);
        REG_SCALED_MAX: scaled_max_q <= $signed(cfg_data_i[VALUE_W-1:0]);
        REG_FULL_SCALE: full_scale_q <= cfg_data_i[FS_W-1:0];
        REG_FILTER_MS:  tau_q        <= cfg_data_i[TAU_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      smoothed_q  <= '0;
      filt_q      <= 1'b0;
      upd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        acc_q <= acc_sat;
      end
      if (state_q == ST_CHECK) begin
        filt_q <= 1'b0;
        upd_q  <= 1'b0;
        if (ready) begin
          acc_q <= '0;
        end
      end
      if (state_q == ST_POST) begin
        if (filt_q) begin
          smoothed_q <= post_sat;
          upd_q      <= 1'b1;
        end else begin
          filt_q <= 1'b1;
        end
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      raw_q <= raw_ext[RAW_BITS-1:0];
    end
    case (state_q)
      ST_CHECK: begin
        dt_q  <= dt_cap;
        den_q <= DEN_W'(fs_eff);
      end
      ST_ABS: begin
        mag_q <= abs_mag[NUM_W-1:0];
        neg_q <= abs_src[PROD_W-1];
      end
      ST_POST: begin
        if (!filt_q) begin
          scaled_q <= post_sat;
          den_q    <= DEN_W'(tau_q) + DEN_W'(dt_q);
        end
      end
      ST_MUL_PREV: begin
        if (mul_done) begin
          p2_q <= NUM_W'(mul_prod >>> TAU_SHIFT);
        end
      end
      ST_MUL_NEW: begin
        if (mul_done) begin
          num_q <= p2_q + NUM_W'(mul_prod >>> DT_SHIFT);
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_value_q <= smoothed_q;
          out_upd_q   <= upd_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_value_o = out_value_q;
  assign updated_o        = out_upd_q;

endmodule

### hdl/asl_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on asl_pkg
module asl_mul (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  asl_pkg::mul_cmd_t                     cmd_i,
  input  logic signed [asl_pkg::MCAND_W-1:0]    mcand_i,
  input  logic        [asl_pkg::MPLIER_W-1:0]   mplier_i,
  output logic                                  done_o,
  output logic signed [asl_pkg::PROD_W-1:0]     prod_o
);
  import asl_pkg::*;

  logic                        busy_q;
  logic                        done_q;
  logic [MUL_CNT_W-1:0]        cnt_q;
  logic signed [MCAND_W:0]     hi_q;
  logic [MPLIER_W-1:0]         lo_q;
  logic signed [MCAND_W-1:0]   mc_q;
  logic signed [MCAND_W:0]     addend;
  logic signed [MCAND_W:0]     sum_d;

  assign addend = lo_q[0] ? $signed({mc_q[MCAND_W-1], mc_q}) : '0;
  assign sum_d  = hi_q + addend;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= cmd_i.count;
    end else if (busy_q) begin
      cnt_q <= cnt_q - MUL_CNT_W'(1);
      if (cnt_q == MUL_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      hi_q <= '0;
      lo_q <= mplier_i;
      mc_q <= mcand_i;
    end else if (busy_q) begin
      // partial sum drops its low bit into the product's low half
      hi_q <= sum_d >>> 1;
      lo_q <= {sum_d[0], lo_q[MPLIER_W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = $signed({hi_q, lo_q});

endmodule

### hdl/asl_div.sv
// restoring radix-2 divider, one quotient bit per cycle
// depends on asl_pkg; numerator comes in left-aligned to its used bits
module asl_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  asl_pkg::div_cmd_t             cmd_i,
  input  logic [asl_pkg::NUM_W-1:0]     num_i,
  input  logic [asl_pkg::DEN_W-1:0]     den_i,
  output logic                          done_o,
  output logic [asl_pkg::NUM_W-1:0]     quo_o
);
  import asl_pkg::*;

  logic                   busy_q;
  logic                   done_q;
  logic [DIV_CNT_W-1:0]   cnt_q;
  logic [NUM_W-1:0]       nq_q;
  logic [DEN_W-1:0]       rem_q;
  logic [DEN_W-1:0]       den_q;
  logic [DEN_W:0]         trial;
  logic [DEN_W+1:0]       diff;
  logic                   qbit;

  assign trial = {rem_q, nq_q[NUM_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_q};
  assign qbit  = ~diff[DEN_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= cmd_i.count;
    end else if (busy_q) begin
      cnt_q <= cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      nq_q  <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      // numerator bits shift out the top, quotient bits fill from the bottom
      nq_q  <= {nq_q[NUM_W-2:0], qbit};
      rem_q <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = nq_q;

endmodule
